### hw/rtl/imu_complementary_tilt_filter_top_assert.svh
// Assertion macros for the tilt filter blocks.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_TOP_ASSERT_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define IMU_CF_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define IMU_CF_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/imu_cf_pkg.sv
// Shared types, constants and tables of the tilt filter.
package imu_cf_pkg;

    localparam int SMP_W = 16;
    localparam int ANG_W = 26;
    localparam int MUL_W = 16;
    localparam int CFG_W = 2;

    localparam logic [CFG_W-1:0] CFG_BLEND_ALPHA = 2'd0;
    localparam logic [CFG_W-1:0] CFG_GYRO_GAIN   = 2'd1;

    localparam logic [MUL_W-1:0] ALPHA_RST = 16'd62415;
    localparam logic [MUL_W-1:0] GAIN_RST  = 16'd5120;

    localparam logic signed [ANG_W-1:0] ANG_MAX = 26'sh1FFFFFF;
    localparam logic signed [ANG_W-1:0] ANG_MIN = -26'sh2000000;

    // CORDIC datapath: vectors scaled by 2^16, angle in 2^-24 degree
    localparam int TBL_FRAC = 24;
    localparam int TBL_LEN  = 24;
    localparam int IDX_W    = 5;
    localparam int CORD_W   = 36;
    localparam int Z_W      = 34;
    localparam int ATAN_W   = 31;

    localparam logic signed [Z_W-1:0] DEG90 = 34'sd1509949440;

    // atan(2^-i) in 2^-24 degree
    localparam logic [ATAN_W-1:0] ATAN_TBL [0:TBL_LEN-1] = '{
        31'd754974720, 31'd445687602, 31'd235489089, 31'd119537938,
        31'd60000934,  31'd30029717,  31'd15018523,  31'd7509720,
        31'd3754917,   31'd1877466,   31'd938734,    31'd469367,
        31'd234684,    31'd117342,    31'd58671,     31'd29335,
        31'd14668,     31'd7334,      31'd3667,      31'd1833,
        31'd917,       31'd458,       31'd229,       31'd115
    };

    // Control of a serial unit: load operands, then advance one step
    typedef struct packed {
        logic load;
        logic step;
    } t_ser_ctl;

endpackage

### hw/rtl/imu_cf_sample_if.sv
// Input sample channel: six raw sensor axes.
interface imu_cf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    output ready);
endinterface

### hw/rtl/imu_cf_angle_if.sv
// Result channel: yaw, pitch and roll angles.
interface imu_cf_angle_if;
    logic               valid;
    logic               ready;
    logic signed [25:0] yaw_out;
    logic signed [25:0] pitch_out;
    logic signed [25:0] roll_out;

    modport source (output valid, yaw_out, pitch_out, roll_out, input ready);
    modport sink   (input valid, yaw_out, pitch_out, roll_out, output ready);
endinterface

### hw/rtl/imu_cf_sermul.sv
// Bit-serial multiplier: signed multiplicand times unsigned 16-bit multiplier, MSB first.
module imu_cf_sermul #(
    parameter int MW = 28
) (
    input  logic                                  i_clk,
    input  imu_cf_pkg::t_ser_ctl                  i_ctl,
    input  logic signed [MW-1:0]                  i_mcand,
    input  logic [imu_cf_pkg::MUL_W-1:0]          i_mplier,
    output logic signed [MW+imu_cf_pkg::MUL_W-1:0] o_prod
);
    import imu_cf_pkg::*;

    localparam int PW = MW + MUL_W;

    logic signed [MW-1:0] r_mcand;
    logic [MUL_W-1:0]     r_mpl;
    logic signed [PW-1:0] r_acc;
    logic signed [PW-1:0] n_acc;

    // one multiplier bit per step: shift and conditionally add
    always_comb begin
        n_acc = (r_acc <<< 1) +
                (r_mpl[MUL_W-1] ? {{MUL_W{r_mcand[MW-1]}}, r_mcand} : {PW{1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mcand <= i_mcand;
            r_mpl   <= i_mplier;
            r_acc   <= '0;
        end else if (i_ctl.step) begin
            r_acc <= n_acc;
            r_mpl <= {r_mpl[MUL_W-2:0], 1'b0};
        end
    end

    assign o_prod = r_acc;
endmodule

### hw/rtl/imu_cf_cordic.sv
// Iterative CORDIC atan2 in vectoring mode, one rotation per step.
module imu_cf_cordic #(
    parameter int FRAC = 16
) (
    input  logic                           i_clk,
    input  imu_cf_pkg::t_ser_ctl           i_ctl,
    input  logic signed [imu_cf_pkg::SMP_W-1:0] i_y,
    input  logic signed [imu_cf_pkg::SMP_W-1:0] i_x,
    output logic signed [FRAC+8:0]         o_angle
);
    import imu_cf_pkg::*;

    localparam int T_W = FRAC + 9;
    localparam int SH  = TBL_FRAC - FRAC;
    localparam logic signed [Z_W-1:0] ROUND = Z_W'(1) <<< (SH - 1);

    logic signed [CORD_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]    r_z;
    logic [IDX_W-1:0]         r_i;
    logic                     r_zero;

    logic signed [CORD_W-1:0] w_xe, w_ye, w_xs, w_ys;
    logic signed [Z_W-1:0]    w_at, w_zr;

    assign w_xe = {{(CORD_W-SMP_W-16){i_x[SMP_W-1]}}, i_x, 16'b0};
    assign w_ye = {{(CORD_W-SMP_W-16){i_y[SMP_W-1]}}, i_y, 16'b0};
    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_at = Z_W'(ATAN_TBL[r_i]);

    // load with quadrant fold, then rotate toward the x axis
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_i    <= '0;
            r_zero <= (i_x == '0) && (i_y == '0);
            if (i_x[SMP_W-1]) begin
                if (!i_y[SMP_W-1]) begin
                    r_x <= w_ye;
                    r_y <= -w_xe;
                    r_z <= DEG90;
                end else begin
                    r_x <= -w_ye;
                    r_y <= w_xe;
                    r_z <= -DEG90;
                end
            end else begin
                r_x <= w_xe;
                r_y <= w_ye;
                r_z <= '0;
            end
        end else if (i_ctl.step) begin
            r_i <= r_i + 1'b1;
            if (!r_y[CORD_W-1]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end
        end
    end

    // round to the output angle format
    assign w_zr    = (r_z + ROUND) >>> SH;
    assign o_angle = r_zero ? '0 : T_W'(w_zr);
endmodule

### hw/rtl/imu_complementary_tilt_filter_top.sv
// Complementary tilt filter: gyro integration blended with accelerometer tilt.
// o_angle.valid rises once an accepted sample beat has been processed: the gyro gain
// products and the two CORDIC atan2 runs go together, one bit or one rotation per cycle,
// then the alpha blend runs as three bit-serial multiplies. A new sample can be accepted
// once the previous result has been written to the output register; while the result
// beat waits there untaken, the next result holds and the input stalls.
module imu_complementary_tilt_filter_top #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [imu_cf_pkg::CFG_W-1:0]      i_cfg_idx,
    input  logic [imu_cf_pkg::MUL_W-1:0]      i_cfg_data,
    imu_cf_sample_if.sink                     i_sample,
    imu_cf_angle_if.source                    o_angle
);
    import imu_cf_pkg::*;

    localparam int T_W     = ANGLE_FRAC_BITS + 9;
    localparam int G_W     = ANG_W + 1;
    localparam int D_W     = ((T_W > G_W) ? T_W : G_W) + 1;
    localparam int P_W     = D_W + MUL_W;
    localparam int S_W     = P_W + 2;
    localparam int RUN_LEN = (CORDIC_STEPS > MUL_W) ? CORDIC_STEPS : MUL_W;
    localparam int CNT_W   = 5;

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_LOADB, S_BLEND, S_FIN} t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [MUL_W-1:0]     r_alpha, r_gain;
    logic signed [ANG_W-1:0] r_yaw, r_pitch, r_roll;
    logic                 r_ov;
    logic signed [ANG_W-1:0] r_oyaw, r_opitch, r_oroll;

    t_ser_ctl             w_mctl, w_cctl;
    logic                 w_acc, w_fin_go;
    logic signed [D_W-1:0] w_mc0, w_mc1, w_mc2;
    logic [MUL_W-1:0]     w_mpl;
    logic signed [P_W-1:0] w_p0, w_p1, w_p2;
    logic signed [T_W-1:0] w_tp, w_tr;
    logic signed [G_W-1:0] w_dz, w_dx, w_dy, w_yg, w_pg, w_rg;
    logic signed [S_W-1:0] w_sy, w_sp, w_sr;
    logic signed [ANG_W-1:0] w_ny, w_np, w_nr;

    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [S_W-1:0] v);
        if (v > S_W'(ANG_MAX))      sat_ang = ANG_MAX;
        else if (v < S_W'(ANG_MIN)) sat_ang = ANG_MIN;
        else                        sat_ang = ANG_W'(v);
    endfunction

    function automatic logic signed [G_W-1:0] gdelta(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] s;
        s = (p + P_W'(128)) >>> 8;
        gdelta = G_W'(s);
    endfunction

    assign w_acc       = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == S_IDLE);
    assign w_fin_go    = (r_state == S_FIN) && (!r_ov || o_angle.ready);

    // serial unit control
    assign w_mctl.load = w_acc || (r_state == S_LOADB);
    assign w_mctl.step = ((r_state == S_RUN) && (r_cnt < CNT_W'(MUL_W))) ||
                         (r_state == S_BLEND);
    assign w_cctl.load = w_acc;
    assign w_cctl.step = (r_state == S_RUN) && (r_cnt < CNT_W'(CORDIC_STEPS));

    // gyro path and blend differences
    always_comb begin
        w_dz = gdelta(w_p0);
        w_dx = gdelta(w_p1);
        w_dy = gdelta(w_p2);
        w_yg = G_W'(r_yaw) + w_dz;
        w_pg = G_W'(r_pitch) + w_dx;
        w_rg = G_W'(r_roll) - w_dy;
        if (r_state == S_IDLE) begin
            w_mc0 = D_W'(i_sample.gyro_z);
            w_mc1 = D_W'(i_sample.gyro_x);
            w_mc2 = D_W'(i_sample.gyro_y);
            w_mpl = r_gain;
        end else begin
            w_mc0 = D_W'(w_yg);
            w_mc1 = D_W'(w_pg) - D_W'(w_tp);
            w_mc2 = D_W'(w_rg) - D_W'(w_tr);
            w_mpl = r_alpha;
        end
    end

    // pitch, roll: a*g + (1-a)*t = a*(g-t) + t; yaw: a*g; all rounded
    always_comb begin
        w_sy = (S_W'(w_p0) + S_W'(32768)) >>> 16;
        w_sp = (S_W'(w_p1) + (S_W'(w_tp) <<< 16) + S_W'(32768)) >>> 16;
        w_sr = (S_W'(w_p2) + (S_W'(w_tr) <<< 16) + S_W'(32768)) >>> 16;
        w_ny = sat_ang(w_sy);
        w_np = sat_ang(w_sp);
        w_nr = sat_ang(w_sr);
    end

    imu_cf_sermul #(.MW(D_W)) u_mul_yaw (
        .i_clk(i_clk), .i_ctl(w_mctl), .i_mcand(w_mc0), .i_mplier(w_mpl), .o_prod(w_p0)
    );
    imu_cf_sermul #(.MW(D_W)) u_mul_pitch (
        .i_clk(i_clk), .i_ctl(w_mctl), .i_mcand(w_mc1), .i_mplier(w_mpl), .o_prod(w_p1)
    );
    imu_cf_sermul #(.MW(D_W)) u_mul_roll (
        .i_clk(i_clk), .i_ctl(w_mctl), .i_mcand(w_mc2), .i_mplier(w_mpl), .o_prod(w_p2)
    );

    imu_cf_cordic #(.FRAC(ANGLE_FRAC_BITS)) u_atan_pitch (
        .i_clk(i_clk), .i_ctl(w_cctl), .i_y(i_sample.accel_y), .i_x(i_sample.accel_z),
        .o_angle(w_tp)
    );
    imu_cf_cordic #(.FRAC(ANGLE_FRAC_BITS)) u_atan_roll (
        .i_clk(i_clk), .i_ctl(w_cctl), .i_y(i_sample.accel_x), .i_x(i_sample.accel_z),
        .o_angle(w_tr)
    );

    // sequencer, angle state, config and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_alpha <= ALPHA_RST;
            r_gain  <= GAIN_RST;
            r_yaw   <= '0;
            r_pitch <= '0;
            r_roll  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLEND_ALPHA: r_alpha <= i_cfg_data;
                    CFG_GYRO_GAIN:   r_gain  <= i_cfg_data;
                    default: ;
                endcase
            end
            // output register: refilled on finish, else emptied when taken
            if (w_fin_go) r_ov <= 1'b1;
            else if (o_angle.ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (w_acc) r_state <= S_RUN;
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(RUN_LEN - 1)) r_state <= S_LOADB;
                end
                S_LOADB: begin
                    r_cnt   <= '0;
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MUL_W - 1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_yaw    <= w_ny;
                        r_pitch  <= w_np;
                        r_roll   <= w_nr;
                        r_oyaw   <= w_ny;
                        r_opitch <= w_np;
                        r_oroll  <= w_nr;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_angle.valid     = r_ov;
    assign o_angle.yaw_out   = r_oyaw;
    assign o_angle.pitch_out = r_opitch;
    assign o_angle.roll_out  = r_oroll;

    `include "imu_complementary_tilt_filter_top_assert.svh"

    `IMU_CF_NEXT(a_accept_starts, w_acc, r_state == S_RUN, "accepted beat did not start run")
    `IMU_CF_IMPL(a_run_bound, r_state == S_RUN, r_cnt < CNT_W'(RUN_LEN), "run counter overran")
    `IMU_CF_NEXT(a_fin_writes, w_fin_go, r_ov && (r_state == S_IDLE), "result not registered")
    `IMU_CF_IMPL(a_no_accept_full, w_acc, r_state == S_IDLE, "beat accepted while busy")
endmodule
